>>> rtl/h2r_pkg.sv
// Shared types and fixed-point constants for the HSL to RGB converter.
`timescale 1ns / 1ps
`default_nettype none

package h2r_pkg;

  // Q0.16 fraction that can also hold exactly 1.0 (65536)
  localparam int unsigned FracW = 17;
  typedef logic [FracW-1:0] frac_t;

  localparam frac_t FracOne   = 17'd65536;
  localparam frac_t FracHalf  = 17'd32768;
  localparam frac_t FracThird = 17'd21845;

  // Pipeline depth of each part
  localparam int unsigned FrontStages = 4;
  localparam int unsigned ChanStages  = 4;
  localparam int unsigned Stages      = FrontStages + ChanStages;

  // Configuration register indexes
  typedef enum logic {
    REG_HUE = 1'b0,
    REG_SAT = 1'b1
  } cfg_reg_e;

  // Per-item values handed from the shared front end to the channel lanes
  typedef struct packed {
    frac_t       p;
    frac_t       q;
    frac_t       t_red;
    frac_t       t_green;
    frac_t       t_blue;
    logic        gray;
    logic [7:0]  light;
  } mid_t;

endpackage

`default_nettype wire

>>> rtl/h2r_front.sv
// Front end: fixed-point setup, q and p, wrapped hue offsets (four stages).
`timescale 1ns / 1ps
`default_nettype none

module h2r_front (
  input  wire logic                                clk_i,
  input  wire logic [h2r_pkg::FrontStages-1:0]     stage_en_i,
  input  wire logic [7:0]                          light_i,
  input  wire logic [8:0]                          hue_i,
  input  wire logic [8:0]                          sat_i,
  output h2r_pkg::mid_t                            mid_o
);
  import h2r_pkg::*;

  // stage 1: range fixes, lightness and saturation as fractions, hue products
  logic [8:0]  hue_w;
  logic [8:0]  sat_c;
  frac_t       lf_1;
  frac_t       sf_1;
  logic [16:0] hmul_1;
  logic [9:0]  hy_1;
  logic [20:0] ymul_1;

  always_comb begin
    hue_w  = (hue_i >= 9'd360) ? (hue_i - 9'd360) : hue_i;
    sat_c  = (sat_i > 9'd256) ? 9'd256 : sat_i;
    // l*131072/510 rounded: 257*l plus one for the upper half
    lf_1   = {1'b0, light_i, light_i} + {16'd0, light_i[7]};
    sf_1   = {sat_c, 8'd0};
    // h*131072/720 rounded = 182*h + (2*h + 22)/45
    hmul_1 = 17'(hue_w) * 17'd182;
    hy_1   = {hue_w, 1'b0} + 10'd22;
    ymul_1 = 21'(hy_1) * 21'd1457;
  end

  logic [7:0]  light_1_q;
  frac_t       lf_1_q;
  frac_t       sf_1_q;
  logic [16:0] hmul_1_q;
  logic [4:0]  hq_1_q;
  logic        gray_1_q;

  always_ff @(posedge clk_i) begin
    if (stage_en_i[0]) begin
      light_1_q <= light_i;
      lf_1_q    <= lf_1;
      sf_1_q    <= sf_1;
      hmul_1_q  <= hmul_1;
      hq_1_q    <= ymul_1[20:16];
      gray_1_q  <= (sat_c == 9'd0);
    end
  end

  // stage 2: hue fraction, l*s product
  frac_t       hf_2;
  logic [33:0] ls_2;

  always_comb begin
    hf_2 = hmul_1_q + {12'd0, hq_1_q};
    ls_2 = 34'(lf_1_q) * 34'(sf_1_q);
  end

  logic [7:0]  light_2_q;
  frac_t       lf_2_q;
  frac_t       sf_2_q;
  frac_t       hf_2_q;
  logic [33:0] ls_2_q;
  logic        gray_2_q;

  always_ff @(posedge clk_i) begin
    if (stage_en_i[1]) begin
      light_2_q <= light_1_q;
      lf_2_q    <= lf_1_q;
      sf_2_q    <= sf_1_q;
      hf_2_q    <= hf_2;
      ls_2_q    <= ls_2;
      gray_2_q  <= gray_1_q;
    end
  end

  // stage 3: round the product, raw q, wrap the red and blue hue offsets
  logic [33:0] ls_rnd;
  frac_t       m_3;
  logic [17:0] q_3;
  logic [17:0] tr_sum;
  frac_t       tr_3;
  frac_t       tb_3;

  always_comb begin
    ls_rnd = ls_2_q + 34'(FracHalf);
    m_3    = ls_rnd[32:16];
    if (lf_2_q < FracHalf) begin
      q_3 = {1'b0, lf_2_q} + {1'b0, m_3};
    end else begin
      q_3 = {1'b0, lf_2_q} + {1'b0, sf_2_q} - {1'b0, m_3};
    end
    tr_sum = {1'b0, hf_2_q} + {1'b0, FracThird};
    tr_3   = (tr_sum > {1'b0, FracOne}) ? 17'(tr_sum - {1'b0, FracOne}) : tr_sum[16:0];
    tb_3   = (hf_2_q < FracThird) ? (hf_2_q + FracOne - FracThird) : (hf_2_q - FracThird);
  end

  logic [7:0]  light_3_q;
  frac_t       lf_3_q;
  logic [17:0] q_3_q;
  frac_t       tr_3_q;
  frac_t       tg_3_q;
  frac_t       tb_3_q;
  logic        gray_3_q;

  always_ff @(posedge clk_i) begin
    if (stage_en_i[2]) begin
      light_3_q <= light_2_q;
      lf_3_q    <= lf_2_q;
      q_3_q     <= q_3;
      tr_3_q    <= tr_3;
      tg_3_q    <= hf_2_q;
      tb_3_q    <= tb_3;
      gray_3_q  <= gray_2_q;
    end
  end

  // stage 4: clamp q into lf..1, form p = 2l - q clamped into 0..q
  frac_t       q_4;
  logic [17:0] two_l;
  logic [17:0] p_raw;
  frac_t       p_4;

  always_comb begin
    if (q_3_q > {1'b0, FracOne}) begin
      q_4 = FracOne;
    end else begin
      q_4 = q_3_q[16:0];
    end
    if (q_4 < lf_3_q) begin
      q_4 = lf_3_q;
    end
    two_l = {lf_3_q, 1'b0};
    p_raw = (two_l > {1'b0, q_4}) ? (two_l - {1'b0, q_4}) : 18'd0;
    p_4   = (p_raw > {1'b0, q_4}) ? q_4 : p_raw[16:0];
  end

  mid_t mid_q;

  always_ff @(posedge clk_i) begin
    if (stage_en_i[3]) begin
      mid_q.p       <= p_4;
      mid_q.q       <= q_4;
      mid_q.t_red   <= tr_3_q;
      mid_q.t_green <= tg_3_q;
      mid_q.t_blue  <= tb_3_q;
      mid_q.gray    <= gray_3_q;
      mid_q.light   <= light_3_q;
    end
  end

  assign mid_o = mid_q;

endmodule

`default_nettype wire

>>> rtl/h2r_chan.sv
// One color channel lane: sector rule, interpolation and 8-bit scaling (four stages).
`timescale 1ns / 1ps
`default_nettype none

module h2r_chan (
  input  wire logic                               clk_i,
  input  wire logic [h2r_pkg::ChanStages-1:0]     stage_en_i,
  input  wire h2r_pkg::mid_t                      mid_i,
  input  wire h2r_pkg::frac_t                     t_i,
  output logic [7:0]                              chan_o
);
  import h2r_pkg::*;

  typedef enum logic [1:0] {
    SEC_RISE = 2'd0,
    SEC_TOP  = 2'd1,
    SEC_FALL = 2'd2,
    SEC_LOW  = 2'd3
  } sec_e;

  // stage 1: pick the sector and the interpolation factor
  logic [18:0] t6;
  logic [18:0] fall_f;
  sec_e        sec_1;
  frac_t       f_1;

  always_comb begin
    t6     = {t_i, 2'b00} + {1'b0, t_i, 1'b0};
    fall_f = 19'd262144 - t6;
    f_1    = '0;
    priority if (t_i <= 17'd10922) begin
      sec_1 = SEC_RISE;
      f_1   = t6[16:0];
    end else if (t_i < 17'd32768) begin
      sec_1 = SEC_TOP;
    end else if (t_i <= 17'd43690) begin
      sec_1 = SEC_FALL;
      f_1   = fall_f[16:0];
    end else begin
      sec_1 = SEC_LOW;
    end
  end

  sec_e        sec_1_q;
  frac_t       f_1_q;
  frac_t       span_1_q;
  frac_t       p_1_q;
  frac_t       q_1_q;
  logic        gray_1_q;
  logic [7:0]  light_1_q;

  always_ff @(posedge clk_i) begin
    if (stage_en_i[0]) begin
      sec_1_q   <= sec_1;
      f_1_q     <= f_1;
      span_1_q  <= mid_i.q - mid_i.p;
      p_1_q     <= mid_i.p;
      q_1_q     <= mid_i.q;
      gray_1_q  <= mid_i.gray;
      light_1_q <= mid_i.light;
    end
  end

  // stage 2: span times factor
  sec_e        sec_2_q;
  logic [33:0] prod_2_q;
  frac_t       p_2_q;
  frac_t       q_2_q;
  logic        gray_2_q;
  logic [7:0]  light_2_q;

  always_ff @(posedge clk_i) begin
    if (stage_en_i[1]) begin
      sec_2_q   <= sec_1_q;
      prod_2_q  <= 34'(span_1_q) * 34'(f_1_q);
      p_2_q     <= p_1_q;
      q_2_q     <= q_1_q;
      gray_2_q  <= gray_1_q;
      light_2_q <= light_1_q;
    end
  end

  // stage 3: channel value as a fraction
  logic [33:0] prod_rnd;
  logic [17:0] v_3;

  always_comb begin
    prod_rnd = prod_2_q + 34'(FracHalf);
    unique case (sec_2_q)
      SEC_RISE, SEC_FALL: v_3 = {1'b0, p_2_q} + {1'b0, prod_rnd[32:16]};
      SEC_TOP:            v_3 = {1'b0, q_2_q};
      SEC_LOW:            v_3 = {1'b0, p_2_q};
      default:            v_3 = {1'b0, p_2_q};
    endcase
  end

  logic [17:0] v_3_q;
  logic        gray_3_q;
  logic [7:0]  light_3_q;

  always_ff @(posedge clk_i) begin
    if (stage_en_i[2]) begin
      v_3_q     <= v_3;
      gray_3_q  <= gray_2_q;
      light_3_q <= light_2_q;
    end
  end

  // stage 4: scale by 255 with rounding, clamp, gray bypass
  logic [25:0] scaled;
  logic [9:0]  c_4;
  logic [7:0]  chan_4;

  always_comb begin
    scaled = {v_3_q, 8'd0} - {8'd0, v_3_q} + 26'(FracHalf);
    c_4    = scaled[25:16];
    if (gray_3_q) begin
      chan_4 = light_3_q;
    end else if (c_4 > 10'd255) begin
      chan_4 = 8'd255;
    end else begin
      chan_4 = c_4[7:0];
    end
  end

  logic [7:0] chan_q;

  always_ff @(posedge clk_i) begin
    if (stage_en_i[3]) begin
      chan_q <= chan_4;
    end
  end

  assign chan_o = chan_q;

endmodule

`default_nettype wire

>>> rtl/hsl_to_rgb_converter.sv
// Top level of the HSL to RGB converter: config registers, pipeline control, lanes.
//
//   channel   | direction | payload (low bits first)          | transfer
//   ----------+-----------+-----------------------------------+---------------------------
//   s_axis    | in        | tdata[7:0] lightness              | tvalid & tready
//   m_axis    | out       | tdata red[7:0] green[15:8] blue[23:16] | tvalid & tready
//   cfg       | in        | addr 0 hue_degrees, 1 saturation  | cfg_we_i, no wait
//
// Eight register stages: four in the shared front end (setup, l*s product, q and
// hue wrap, p), four in each color lane (sector, span product, interpolation, scale).
// One transaction enters every cycle while no output stall backs up to the input,
// set by the 17x17 multipliers that each own a stage.
// Each stage holds its own valid bit and advances when empty or when the stage after
// it advances, so a stalled output fills bubbles and never drops or repeats data.
// Reset clears the valid bits and loads hue 200 and saturation 192.
`timescale 1ns / 1ps
`default_nettype none

module hsl_to_rgb_converter (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration write port
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_addr_i,
  input  wire logic [8:0]  cfg_data_i,
  // input stream
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] lightness
  // output stream
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [23:0]      m_axis_tdata_o    // [7:0] red, [15:8] green, [23:16] blue
);
  import h2r_pkg::*;

  // configuration registers
  logic [8:0] hue_q, hue_d;
  logic [8:0] sat_q, sat_d;

  always_comb begin
    hue_d = hue_q;
    sat_d = sat_q;
    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        REG_HUE: hue_d = cfg_data_i;
        REG_SAT: sat_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hue_q <= 9'd200;
      sat_q <= 9'd192;
    end else begin
      hue_q <= hue_d;
      sat_q <= sat_d;
    end
  end

  // stage valid bits and advance enables; a stage moves when empty or when
  // the stage after it moves
  logic [Stages-1:0] valid_q, valid_d;
  logic [Stages-1:0] stage_en;

  always_comb begin
    stage_en[Stages-1] = ~valid_q[Stages-1] | m_axis_tready_i;
    for (int k = Stages - 2; k >= 0; k--) begin
      stage_en[k] = ~valid_q[k] | stage_en[k+1];
    end
    valid_d[0] = stage_en[0] ? s_axis_tvalid_i : valid_q[0];
    for (int k = 1; k < Stages; k++) begin
      valid_d[k] = stage_en[k] ? valid_q[k-1] : valid_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign s_axis_tready_o = stage_en[0];
  assign m_axis_tvalid_o = valid_q[Stages-1];

  // shared front end
  mid_t mid;

  h2r_front u_front (
    .clk_i      (clk_i),
    .stage_en_i (stage_en[FrontStages-1:0]),
    .light_i    (s_axis_tdata_i),
    .hue_i      (hue_q),
    .sat_i      (sat_q),
    .mid_o      (mid)
  );

  // one lane per color, differing only in hue offset
  logic [7:0] red, green, blue;

  h2r_chan u_chan_red (
    .clk_i      (clk_i),
    .stage_en_i (stage_en[Stages-1:FrontStages]),
    .mid_i      (mid),
    .t_i        (mid.t_red),
    .chan_o     (red)
  );

  h2r_chan u_chan_green (
    .clk_i      (clk_i),
    .stage_en_i (stage_en[Stages-1:FrontStages]),
    .mid_i      (mid),
    .t_i        (mid.t_green),
    .chan_o     (green)
  );

  h2r_chan u_chan_blue (
    .clk_i      (clk_i),
    .stage_en_i (stage_en[Stages-1:FrontStages]),
    .mid_i      (mid),
    .t_i        (mid.t_blue),
    .chan_o     (blue)
  );

  assign m_axis_tdata_o = {blue, green, red};

`ifndef SYNTHESIS
  // input backs up only when every stage is occupied
  a_full_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (&valid_q))
    else $error("input stalled with a bubble in the pipeline");

  // an accepted transaction lands in the first stage
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> valid_q[0])
    else $error("accepted transaction lost at entry");

  // a held middle stage keeps its transaction
  a_hold_mid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q[FrontStages-1] && !stage_en[FrontStages-1]) |=> valid_q[FrontStages-1])
    else $error("held stage dropped its transaction");

  // new output only comes from the stage before it
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(valid_q[Stages-2]))
    else $error("output valid without a transaction behind it");
`endif

endmodule

`default_nettype wire

>>> test/testbench.sv
// Self-checking testbench for the HSL to RGB converter: streams lightness samples, checks each RGB pixel.
`timescale 1ns / 1ps

module testbench;
  import h2r_pkg::*;

  // What one entry of the stimulus plan asks the driver to do
  typedef enum logic [1:0] {
    ACT_PIXEL,   // present one lightness sample
    ACT_WRITE,   // write one config register once the pipeline is empty
    ACT_HOLD     // hold off the sender until every pixel has come back
  } plan_act_e;

  typedef struct {
    plan_act_e  act;
    logic [7:0] light;
    cfg_reg_e   reg_sel;
    logic [8:0] reg_val;
    bit         calm;      // no idling on either side while this is in flight
  } plan_step_t;

  // Pixel layout of m_axis_tdata: red lowest, blue highest
  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rgb_t;

  localparam int unsigned MaxReports  = 10;
  localparam int unsigned RandomItems = 1250;
  localparam int unsigned CalmTail    = 150;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        cfg_we_i        = 1'b0;
  cfg_reg_e    cfg_addr_i      = REG_HUE;
  logic [8:0]  cfg_data_i      = '0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i  = '0;   // [7:0] lightness
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [23:0] m_axis_tdata_o;         // [7:0] red, [15:8] green, [23:16] blue

  plan_step_t pixel_plan_q[$];
  rgb_t       rgb_expected_q[$];

  bit calm_now = 1'b0;
  int gap_left, stall_left;
  int pixels_sent, pixels_back;       // driver's view of transactions in flight
  int pixels_checked, fail_count, reg_writes, planned_pixels;
  logic [8:0] hue_shadow, sat_shadow;

  hsl_to_rgb_converter i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Hard stop: far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("timeout: %0d pixels still expected", rgb_expected_q.size());
    $display("testbench: FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor. Hue offsets are wrapped into one turn, an offset of exactly one
  // turn is kept and lands in the last sector.
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] lane_level(frac_t p, frac_t q, int t);
    longint unsigned span, t6, v, c;
    if (t < 0) t += int'(FracOne);
    if (t > int'(FracOne)) t -= int'(FracOne);
    span = q - p;
    t6   = longint'(t) * 6;
    if (t6 < FracOne)
      v = p + ((span * t6 + FracHalf) >> 16);
    else if (longint'(t) * 2 < FracOne)
      v = q;
    else if (longint'(t) * 3 < 2 * FracOne)
      v = p + ((span * (4 * FracOne - t6) + FracHalf) >> 16);
    else
      v = p;
    c = (v * 255 + FracHalf) >> 16;
    return (c > 255) ? 8'd255 : c[7:0];
  endfunction

  function automatic rgb_t hsl_pixel_to_rgb(logic [7:0] light, logic [8:0] hue_reg,
                                            logic [8:0] sat_reg);
    logic [8:0]      hue, sat;
    longint unsigned lf, sf, hf, m, qw, pw;
    frac_t           p, q;
    rgb_t            px;
    hue = (hue_reg >= 9'd360) ? hue_reg - 9'd360 : hue_reg;
    sat = (sat_reg > 9'd256) ? 9'd256 : sat_reg;
    // No saturation: plain grey
    if (sat == 0) begin
      px.red   = light;
      px.green = light;
      px.blue  = light;
      return px;
    end
    lf = (longint'(light) * 131072 + 255) / 510;
    sf = longint'(sat) * 256;
    hf = (longint'(hue) * 131072 + 360) / 720;
    m  = (lf * sf + FracHalf) >> 16;
    qw = (lf < FracHalf) ? lf + m : lf + sf - m;
    if (qw > FracOne) qw = FracOne;
    if (qw < lf) qw = lf;
    pw = (2 * lf > qw) ? 2 * lf - qw : 0;
    if (pw > qw) pw = qw;
    q = frac_t'(qw);
    p = frac_t'(pw);
    px.red   = lane_level(p, q, int'(hf) + int'(FracThird));
    px.green = lane_level(p, q, int'(hf));
    px.blue  = lane_level(p, q, int'(hf) - int'(FracThird));
    return px;
  endfunction

  // ---------------------------------------------------------------------------
  // Plan builders
  // ---------------------------------------------------------------------------
  task automatic plan_pixel(logic [7:0] light, bit calm);
    plan_step_t s;
    s.act = ACT_PIXEL; s.light = light; s.reg_sel = REG_HUE; s.reg_val = '0; s.calm = calm;
    pixel_plan_q.push_back(s);
    planned_pixels++;
  endtask

  task automatic plan_write(cfg_reg_e sel, logic [8:0] value);
    plan_step_t s;
    s.act = ACT_WRITE; s.light = '0; s.reg_sel = sel; s.reg_val = value; s.calm = 1'b0;
    pixel_plan_q.push_back(s);
  endtask

  task automatic plan_hold();
    plan_step_t s;
    s.act = ACT_HOLD; s.light = '0; s.reg_sel = REG_HUE; s.reg_val = '0; s.calm = 1'b0;
    pixel_plan_q.push_back(s);
  endtask

  task automatic plan_setting(logic [8:0] hue, logic [8:0] sat);
    plan_write(REG_HUE, hue);
    plan_write(REG_SAT, sat);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: feed the input stream and the config port from the plan. A config
  // write or a hold waits until every accepted sample has produced its pixel,
  // so the pipeline is empty when the register changes.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : driver
    logic       next_valid;
    logic [7:0] next_light;
    logic       next_we;
    cfg_reg_e   next_sel;
    logic [8:0] next_val;
    plan_step_t head;
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= '0;
      cfg_we_i        <= 1'b0;
      cfg_addr_i      <= REG_HUE;
      cfg_data_i      <= '0;
      gap_left    = 0;
      pixels_sent = 0;
      pixels_back = 0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) pixels_sent++;
      if (m_axis_tvalid_o && m_axis_tready_i) pixels_back++;
      // Hold the current sample until it is taken
      next_valid = s_axis_tvalid_i && !s_axis_tready_o;
      next_light = s_axis_tdata_i;
      next_we    = 1'b0;
      next_sel   = cfg_addr_i;
      next_val   = cfg_data_i;
      if (!next_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pixel_plan_q.size() != 0) begin
          head = pixel_plan_q[0];
          case (head.act)
            ACT_PIXEL: begin
              // Insert an idle burst now and then
              if (!head.calm && $urandom_range(0, 5) == 0) begin
                gap_left = $urandom_range(0, 2);
              end else begin
                next_valid = 1'b1;
                next_light = head.light;
                calm_now  <= head.calm;
                pixel_plan_q.delete(0);
              end
            end
            ACT_WRITE: begin
              if (pixels_sent == pixels_back) begin
                next_we  = 1'b1;
                next_sel = head.reg_sel;
                next_val = head.reg_val;
                reg_writes++;
                pixel_plan_q.delete(0);
              end
            end
            ACT_HOLD: begin
              if (pixels_sent == pixels_back) pixel_plan_q.delete(0);
            end
            default: pixel_plan_q.delete(0);
          endcase
        end
      end
      s_axis_tvalid_i <= next_valid;
      s_axis_tdata_i  <= next_light;
      cfg_we_i        <= next_we;
      cfg_addr_i      <= next_sel;
      cfg_data_i      <= next_val;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict on every accepted sample, track register writes as the
  // block sees them, check every accepted pixel, and stall the output at random.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    rgb_t want, got;
    logic ready_next;
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
      stall_left = 0;
      hue_shadow = 9'd200;
      sat_shadow = 9'd192;
    end else begin
      // Predict with the settings in force before this edge's write
      if (s_axis_tvalid_i && s_axis_tready_o)
        rgb_expected_q.push_back(hsl_pixel_to_rgb(s_axis_tdata_i, hue_shadow, sat_shadow));
      if (cfg_we_i) begin
        case (cfg_addr_i)
          REG_HUE: hue_shadow = cfg_data_i;
          REG_SAT: sat_shadow = cfg_data_i;
          default: ;
        endcase
      end
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got = rgb_t'(m_axis_tdata_o);
        if (rgb_expected_q.size() == 0) begin
          fail_count++;
          if (fail_count <= MaxReports)
            $display("%0t: unexpected pixel r=%0d g=%0d b=%0d", $realtime,
                     got.red, got.green, got.blue);
        end else begin
          want = rgb_expected_q.pop_front();
          pixels_checked++;
          if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue) begin
            fail_count++;
            if (fail_count <= MaxReports)
              $display("%0t: pixel %0d mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                       $realtime, pixels_checked, want.red, want.green, want.blue,
                       got.red, got.green, got.blue);
          end
        end
      end
      // Back-pressure in random bursts
      if (stall_left > 0) begin
        stall_left--;
        ready_next = 1'b0;
      end else if (!calm_now && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 2);
        ready_next = 1'b0;
      end else begin
        ready_next = 1'b1;
      end
      m_axis_tready_i <= ready_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int         n, len, hold_at;
    bit         seg_calm;
    logic [8:0] hue, sat;
    logic [7:0] light;

    // Reset settings (hue 200, saturation 192), lightness extremes
    plan_pixel(8'd0, 1'b0);
    plan_pixel(8'd255, 1'b0);
    plan_pixel(8'd128, 1'b0);
    plan_pixel(8'd127, 1'b0);
    plan_pixel(8'd85, 1'b0);
    // Hue zero: blue offset falls below zero and wraps
    plan_setting(9'd0, 9'd256);
    plan_pixel(8'd0, 1'b0);
    plan_pixel(8'd255, 1'b0);
    plan_pixel(8'd170, 1'b0);
    // Hue 240: red offset lands on exactly one turn and gives p
    plan_setting(9'd240, 9'd256);
    plan_pixel(8'd128, 1'b0);
    plan_pixel(8'd64, 1'b0);
    // Zero saturation: grey
    plan_setting(9'd120, 9'd0);
    plan_pixel(8'hAA, 1'b0);
    plan_pixel(8'h55, 1'b0);
    plan_pixel(8'd255, 1'b0);
    // All register bits set: hue wraps, saturation clamps to full
    plan_setting(9'd511, 9'd511);
    plan_pixel(8'd200, 1'b0);
    plan_pixel(8'd37, 1'b0);
    // Top of the hue range, weakest saturation
    plan_setting(9'd359, 9'd1);
    plan_pixel(8'd128, 1'b0);
    plan_pixel(8'd1, 1'b0);
    // Just beyond both ranges
    plan_setting(9'd360, 9'd257);
    plan_pixel(8'd100, 1'b0);
    plan_pixel(8'd254, 1'b0);
    plan_setting(9'd60, 9'd128);
    plan_pixel(8'd42, 1'b0);

    // Random phases: a new saturation and mostly a new hue, then a run of random samples
    n = 0;
    while (n < RandomItems) begin
      seg_calm = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 7))
        0:       hue = 9'd0;
        1:       hue = 9'd359;
        2:       hue = 9'($urandom_range(360, 511));
        default: hue = 9'($urandom_range(0, 359));
      endcase
      case ($urandom_range(0, 9))
        0:       sat = 9'd0;
        1:       sat = 9'd256;
        2:       sat = 9'($urandom_range(257, 511));
        3:       sat = 9'($urandom_range(1, 8));
        default: sat = 9'($urandom_range(1, 255));
      endcase
      if ($urandom_range(0, 4) != 0) plan_write(REG_HUE, hue);
      plan_write(REG_SAT, sat);
      len     = $urandom_range(10, 60);
      hold_at = ($urandom_range(0, 2) == 0) ? $urandom_range(1, len - 1) : -1;
      for (int i = 0; i < len; i++) begin
        if (i == hold_at) plan_hold();
        case ($urandom_range(0, 9))
          0:       light = 8'd0;
          1:       light = 8'd255;
          default: light = 8'($urandom_range(0, 255));
        endcase
        plan_pixel(light, seg_calm || (n >= RandomItems - CalmTail));
        n++;
      end
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Drain the plan, then every expected pixel, then let the pipeline settle
    while (pixel_plan_q.size() != 0 || s_axis_tvalid_i) @(posedge clk_i);
    while (rgb_expected_q.size() != 0) @(posedge clk_i);
    repeat (4 * Stages) @(posedge clk_i);

    $display("run: %0d lightness samples, %0d pixels checked, %0d register writes",
             planned_pixels, pixels_checked, reg_writes);
    $display("run: hue and saturation swept across wrap, clamp and grey settings, %0d failures",
             fail_count);
    if (fail_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/h2r_pkg.sv
rtl/h2r_front.sv
rtl/h2r_chan.sv
rtl/hsl_to_rgb_converter.sv
test/testbench.sv
